FILE: design/mvp_pkg.sv
`default_nettype none

package mvp_pkg;

   // Payload store depth and the address width that follows from it.
   localparam int MAX_PAYLOAD = 32;
   localparam int PAY_AW      = $clog2(MAX_PAYLOAD);

   localparam logic [7:0]  SYNC_BYTE      = 8'hFE;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [7:0]  GPS_RAW_INT_ID = 8'd24;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_LEN,
      ST_SEQ,
      ST_SYS,
      ST_COMP,
      ST_MSGID,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_FETCH,
      ST_LOAD
   } mvp_state_type;

   typedef struct packed {
      logic known;
      logic [7:0] len;
      logic [7:0] extra;
   } mvp_msg_info_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic frame_start;
      logic crc_accum;
      logic len_we;
      logic sys_we;
      logic msgid_we;
      logic pay_we;
      logic crc_lo_we;
      logic emit_start;
      logic out_load;
   } mvp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_sync;
      logic id_ok;
      logic pay_done;
      logic crc_match;
      logic emit_last;
      logic out_free;
   } mvp_sts_type;

   // One byte of the X.25 (MCRF4XX) CRC accumulate.
   function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'h0};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

   // Known message ids with their standard lengths and CRC extra bytes.
   function automatic mvp_msg_info_type msg_lookup(input logic [7:0] id);
      mvp_msg_info_type info;
      case (id)
         8'd0:    info = '{known: 1'b1, len: 8'd9,  extra: 8'd50};
         8'd1:    info = '{known: 1'b1, len: 8'd31, extra: 8'd124};
         8'd24:   info = '{known: 1'b1, len: 8'd30, extra: 8'd24};
         8'd30:   info = '{known: 1'b1, len: 8'd28, extra: 8'd39};
         8'd35:   info = '{known: 1'b1, len: 8'd22, extra: 8'd244};
         8'd74:   info = '{known: 1'b1, len: 8'd20, extra: 8'd20};
         default: info = '{known: 1'b0, len: 8'd0,  extra: 8'd0};
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

FILE: design/mvp_req_if.sv
`default_nettype none

interface mvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: design/mvp_rsp_if.sv
`default_nettype none

interface mvp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_id;
   logic [7:0] sys_id;
   logic [7:0] payload_byte;
   logic [4:0] byte_index;
   logic       last;
   logic       gps_frame;

   modport source (output valid, output msg_id, output sys_id, output payload_byte,
                   output byte_index, output last, output gps_frame, input ready);
   modport sink   (input valid, input msg_id, input sys_id, input payload_byte,
                   input byte_index, input last, input gps_frame, output ready);
endinterface

`default_nettype wire

FILE: design/mvp_ctrl.sv
`default_nettype none

module mvp_ctrl
   import mvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire mvp_sts_type sts,
   output mvp_cmd_type      cmd
);

   mvp_state_type state_ff, state_in;
   logic          acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff != ST_FETCH) && (state_ff != ST_LOAD);
      acc       = req_valid && req_ready;
      case (state_ff)
         ST_HUNT: begin
            if (acc && sts.is_sync) begin
               cmd.frame_start = 1'b1;
               state_in        = ST_LEN;
            end
         end
         ST_LEN: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               cmd.len_we    = 1'b1;
               state_in      = ST_SEQ;
            end
         end
         ST_SEQ: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               state_in      = ST_SYS;
            end
         end
         ST_SYS: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               cmd.sys_we    = 1'b1;
               state_in      = ST_COMP;
            end
         end
         ST_COMP: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               state_in      = ST_MSGID;
            end
         end
         ST_MSGID: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               cmd.msgid_we  = 1'b1;
               state_in      = sts.id_ok ? ST_PAYLOAD : ST_HUNT;
            end
         end
         ST_PAYLOAD: begin
            if (acc) begin
               cmd.crc_accum = 1'b1;
               cmd.pay_we    = 1'b1;
               if (sts.pay_done) begin
                  state_in = ST_CRC_LO;
               end
            end
         end
         ST_CRC_LO: begin
            if (acc) begin
               cmd.crc_lo_we = 1'b1;
               state_in      = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (acc) begin
               if (sts.crc_match) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_FETCH;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.emit_last ? ST_HUNT : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/mvp_dp.sv
`default_nettype none

module mvp_dp
   import mvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  rx_byte,
   input  wire mvp_cmd_type cmd,
   output mvp_sts_type      sts,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       rsp_msg_id,
   output logic [7:0]       rsp_sys_id,
   output logic [7:0]       rsp_payload_byte,
   output logic [4:0]       rsp_byte_index,
   output logic             rsp_last,
   output logic             rsp_gps_frame
);

   logic [7:0]  frame_length_ff;
   logic [7:0]  frame_msg_id_ff;
   logic [7:0]  frame_sys_id_ff;
   logic [5:0]  payload_count_ff;
   logic [15:0] crc_ff;
   logic [7:0]  crc_low_ff;
   logic [7:0]  crc_extra_ff;
   logic [4:0]  emit_idx_ff;
   logic [7:0]  rd_data_ff;
   logic [7:0]  store [MAX_PAYLOAD];

   logic             out_valid_ff;
   logic [7:0]       out_msg_id_ff;
   logic [7:0]       out_sys_id_ff;
   logic [7:0]       out_byte_ff;
   logic [4:0]       out_index_ff;
   logic             out_last_ff;
   logic             out_gps_ff;

   mvp_msg_info_type info;
   logic [5:0]       count_inc;
   logic [15:0]      crc_final;

   assign info      = msg_lookup(rx_byte);
   assign count_inc = payload_count_ff + 6'd1;
   assign crc_final = x25_update(crc_ff, crc_extra_ff);

   always_comb begin
      sts.is_sync   = (rx_byte == SYNC_BYTE);
      sts.id_ok     = info.known && (info.len == frame_length_ff);
      sts.pay_done  = ({2'b00, count_inc} == frame_length_ff);
      sts.crc_match = ({rx_byte, crc_low_ff} == crc_final);
      sts.emit_last = (({3'b000, emit_idx_ff} + 8'd1) == frame_length_ff);
      sts.out_free  = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff           <= CRC_INIT;
         payload_count_ff <= '0;
         emit_idx_ff      <= '0;
      end else begin
         if (cmd.frame_start) begin
            crc_ff           <= CRC_INIT;
            payload_count_ff <= '0;
         end else begin
            if (cmd.crc_accum) begin
               crc_ff <= x25_update(crc_ff, rx_byte);
            end
            if (cmd.pay_we) begin
               payload_count_ff <= count_inc;
            end
         end
         if (cmd.emit_start) begin
            emit_idx_ff <= '0;
         end else if (cmd.out_load) begin
            emit_idx_ff <= emit_idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.len_we) begin
         frame_length_ff <= rx_byte;
      end
      if (cmd.sys_we) begin
         frame_sys_id_ff <= rx_byte;
      end
      if (cmd.msgid_we) begin
         frame_msg_id_ff <= rx_byte;
         crc_extra_ff    <= info.extra;
      end
      if (cmd.crc_lo_we) begin
         crc_low_ff <= rx_byte;
      end
   end

   // Payload store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.pay_we && ({2'b00, payload_count_ff} < 8'(MAX_PAYLOAD))) begin
         store[payload_count_ff[PAY_AW-1:0]] <= rx_byte;
      end
      rd_data_ff <= store[emit_idx_ff[PAY_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_msg_id_ff <= frame_msg_id_ff;
         out_sys_id_ff <= frame_sys_id_ff;
         out_byte_ff   <= rd_data_ff;
         out_index_ff  <= emit_idx_ff;
         out_last_ff   <= sts.emit_last;
         out_gps_ff    <= (frame_msg_id_ff == GPS_RAW_INT_ID);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_msg_id       = out_msg_id_ff;
   assign rsp_sys_id       = out_sys_id_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_gps_frame    = out_gps_ff;

endmodule

`default_nettype wire

FILE: design/mavlink_v1_frame_parser.sv
`default_nettype none

// MAVLink v1 receive parser. Serial bytes enter one item at a time on req_ch; the parser
// hunts for the 0xFE sync byte, collects the header, checks the message id against six
// known messages (HEARTBEAT, SYS_STATUS, GPS_RAW_INT, ATTITUDE, RC_CHANNELS_RAW, VFR_HUD)
// and their standard lengths, buffers the payload and verifies the X.25 CRC including the
// per-message extra byte. A frame that passes comes out on rsp_ch as one item per payload
// byte, with msg_id, sys_id, the byte index and a last marker on the final byte; frames
// that fail any check are dropped silently and the parser goes back to hunting. Every
// received byte is taken as soon as it is offered, except after the CRC high byte of a good
// frame, when the input is held off while the payload is played out of the 32-byte store:
// for each payload byte a registered memory read and then a load of the output register,
// which waits while the sink stalls. The output register lets the next frame start while
// the final item still waits.

module mavlink_v1_frame_parser
   import mvp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mvp_req_if.sink   req_ch,
   mvp_rsp_if.source rsp_ch
);

   mvp_cmd_type cmd;
   mvp_sts_type sts;

   // The controller sequences the frame phases and the payload burst.
   mvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the header fields, the running CRC, the payload store
   // and the output register.
   mvp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .rx_byte          (req_ch.rx_byte),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_msg_id       (rsp_ch.msg_id),
      .rsp_sys_id       (rsp_ch.sys_id),
      .rsp_payload_byte (rsp_ch.payload_byte),
      .rsp_byte_index   (rsp_ch.byte_index),
      .rsp_last         (rsp_ch.last),
      .rsp_gps_frame    (rsp_ch.gps_frame)
   );

`ifndef SYNTHESIS
   // The last item of a frame sits at the final index of one of the known lengths.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last) |->
         (rsp_ch.byte_index == 5'd8 || rsp_ch.byte_index == 5'd30 ||
          rsp_ch.byte_index == 5'd29 || rsp_ch.byte_index == 5'd27 ||
          rsp_ch.byte_index == 5'd21 || rsp_ch.byte_index == 5'd19))
      else $error("last marker on an index that ends no known frame");

   // The GPS flag follows the message id of the item.
   a_gps_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.gps_frame == (rsp_ch.msg_id == GPS_RAW_INT_ID)))
      else $error("gps_frame disagrees with msg_id");

   // Input is only held off right after a byte was taken (the CRC high byte).
   a_hold_after_byte: assert property (@(posedge clock) disable iff (reset)
      (!req_ch.ready && $past(req_ch.ready) && !$past(reset)) |-> $past(req_ch.valid))
      else $error("input held off without a received byte");

   // A new item enters the output register only while input is held off.
   a_emit_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !$past(rsp_ch.valid) && !$past(reset)) |-> !$past(req_ch.ready))
      else $error("result appeared outside the payload burst");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_mavlink_v1_frame_parser.sv
import mvp_pkg::*;

// Message ids that the parser accepts. GPS_RAW_INT comes from the package.
localparam logic [7:0] ID_HEARTBEAT       = 8'd0;
localparam logic [7:0] ID_SYS_STATUS      = 8'd1;
localparam logic [7:0] ID_ATTITUDE        = 8'd30;
localparam logic [7:0] ID_RC_CHANNELS_RAW = 8'd35;
localparam logic [7:0] ID_VFR_HUD         = 8'd74;

typedef struct packed {
   logic [7:0] msg_id;
   logic [7:0] sys_id;
   logic [7:0] payload_byte;
   logic [4:0] byte_index;
   logic       last;
   logic       gps_frame;
} payload_item_type;

// Bit-serial form of the reflected CCITT polynomial, one byte per call.
function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] b);
   logic [15:0] acc;
   acc = crc ^ {8'h00, b};
   for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
         acc = (acc >> 1) ^ 16'h8408;
      end else begin
         acc = acc >> 1;
      end
   end
   return acc;
endfunction

// Standard length and CRC extra of a known id; returns 0 for an unknown id.
function automatic bit std_msg_params(input logic [7:0] id, output logic [7:0] len,
                                      output logic [7:0] extra);
   len   = 8'd0;
   extra = 8'd0;
   case (id)
      ID_HEARTBEAT: begin
         len = 8'd9;  extra = 8'd50;
      end
      ID_SYS_STATUS: begin
         len = 8'd31; extra = 8'd124;
      end
      GPS_RAW_INT_ID: begin
         len = 8'd30; extra = 8'd24;
      end
      ID_ATTITUDE: begin
         len = 8'd28; extra = 8'd39;
      end
      ID_RC_CHANNELS_RAW: begin
         len = 8'd22; extra = 8'd244;
      end
      ID_VFR_HUD: begin
         len = 8'd20; extra = 8'd20;
      end
      default: return 1'b0;
   endcase
   return 1'b1;
endfunction

class frame_scoreboard;
   mvp_state_type    phase;
   logic [7:0]       hdr_len;
   logic [7:0]       hdr_sys;
   logic [7:0]       hdr_msg;
   logic [7:0]       crc_lo;
   logic [7:0]       crc_extra;
   logic [5:0]       pay_cnt;
   logic [15:0]      crc_acc;
   logic [7:0]       pay_buf [MAX_PAYLOAD];
   payload_item_type expected_items [$];
   int               mismatches;
   int               checked;
   int               frames_passed;

   function new();
      phase         = ST_HUNT;
      hdr_len       = 8'd0;
      hdr_sys       = 8'd0;
      hdr_msg       = 8'd0;
      crc_lo        = 8'd0;
      crc_extra     = 8'd0;
      pay_cnt       = 6'd0;
      crc_acc       = CRC_INIT;
      mismatches    = 0;
      checked       = 0;
      frames_passed = 0;
   endfunction

   task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Advances the parser copy by one accepted byte and queues any payload items.
   function void note_rx_byte(input logic [7:0] c);
      logic [7:0]       std_len;
      logic [7:0]       std_extra;
      logic [15:0]      calc;
      payload_item_type item;
      if (phase >= ST_LEN && phase <= ST_PAYLOAD) crc_acc = x25_fold(crc_acc, c);
      case (phase)
         ST_HUNT: begin
            if (c == SYNC_BYTE) begin
               crc_acc = CRC_INIT;
               pay_cnt = 6'd0;
               phase   = ST_LEN;
            end
         end
         ST_LEN: begin
            hdr_len = c;
            phase   = ST_SEQ;
         end
         ST_SEQ:  phase = ST_SYS;
         ST_SYS: begin
            hdr_sys = c;
            phase   = ST_COMP;
         end
         ST_COMP: phase = ST_MSGID;
         ST_MSGID: begin
            hdr_msg = c;
            if (std_msg_params(c, std_len, std_extra) && std_len == hdr_len) begin
               crc_extra = std_extra;
               phase     = ST_PAYLOAD;
            end else begin
               phase = ST_HUNT;
            end
         end
         ST_PAYLOAD: begin
            if (pay_cnt < MAX_PAYLOAD) pay_buf[pay_cnt[4:0]] = c;
            pay_cnt = pay_cnt + 6'd1;
            if ({2'b00, pay_cnt} == hdr_len) phase = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            crc_lo = c;
            phase  = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            calc    = x25_fold(crc_acc, crc_extra);
            crc_acc = calc;
            if ({c, crc_lo} == calc) begin
               frames_passed++;
               for (int i = 0; i < hdr_len && i < MAX_PAYLOAD && i < 31; i++) begin
                  item.msg_id       = hdr_msg;
                  item.sys_id       = hdr_sys;
                  item.payload_byte = pay_buf[i];
                  item.byte_index   = 5'(i);
                  item.last         = (i + 1 == hdr_len);
                  item.gps_frame    = (hdr_msg == GPS_RAW_INT_ID);
                  expected_items.push_back(item);
               end
            end
            phase = ST_HUNT;
         end
         default: phase = ST_HUNT;
      endcase
   endfunction

   task check_result(input payload_item_type got);
      payload_item_type want;
      if (expected_items.size() == 0) begin
         report_mismatch($sformatf("unexpected item: msg %0d index %0d byte %02h",
                                   got.msg_id, got.byte_index, got.payload_byte));
         return;
      end
      want = expected_items.pop_front();
      checked++;
      if (got.msg_id !== want.msg_id)
         report_mismatch($sformatf("msg_id at index %0d: expected %0d, got %0d",
                                   want.byte_index, want.msg_id, got.msg_id));
      if (got.sys_id !== want.sys_id)
         report_mismatch($sformatf("sys_id at index %0d: expected %02h, got %02h",
                                   want.byte_index, want.sys_id, got.sys_id));
      if (got.payload_byte !== want.payload_byte)
         report_mismatch($sformatf("payload_byte at index %0d: expected %02h, got %02h",
                                   want.byte_index, want.payload_byte, got.payload_byte));
      if (got.byte_index !== want.byte_index)
         report_mismatch($sformatf("byte_index: expected %0d, got %0d",
                                   want.byte_index, got.byte_index));
      if (got.last !== want.last)
         report_mismatch($sformatf("last at index %0d: expected %0b, got %0b",
                                   want.byte_index, want.last, got.last));
      if (got.gps_frame !== want.gps_frame)
         report_mismatch($sformatf("gps_frame at index %0d: expected %0b, got %0b",
                                   want.byte_index, want.gps_frame, got.gps_frame));
   endtask
endclass

module tb_mavlink_v1_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;

   // Bytes of frames and broken headers to offer in the random part. Noise bytes between
   // frames, the directed part and the tail of the last frame bring the run to about 470
   // items.
   localparam int TOTAL_BYTES    = 420;
   // Once this many bytes have gone out, both sides stop idling.
   localparam int CALM_TAIL_AT   = 350;
   // Long receiver hold-off that backs the parser up into its input.
   localparam int LONG_HOLD      = 400;
   // The longest correct quiet stretch is the long hold-off; this is several times that.
   localparam int WATCHDOG_LIMIT = 3000;
   // Margin for a full 31-byte frame to play out into a ready sink.
   localparam int DRAIN_CYCLES   = 100;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_ID,
      FRAME_BAD_LEN
   } frame_kind_type;

   logic clock;
   logic reset;

   mvp_req_if req_bus ();
   mvp_rsp_if rsp_bus ();

   mavlink_v1_frame_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   frame_scoreboard sb;

   // Bytes of the frame being built, sync byte first.
   logic [7:0] frame_buf [$];

   // The sender raises long_hold_req; the receiver takes it and clears it.
   bit calm_tail;
   bit long_hold_req;

   int frames_good;
   int frames_broken;
   int noise_bytes;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [7:0] pick_known_id(input int k);
      case (k)
         0:       return ID_HEARTBEAT;
         1:       return ID_SYS_STATUS;
         2:       return GPS_RAW_INT_ID;
         3:       return ID_ATTITUDE;
         4:       return ID_RC_CHANNELS_RAW;
         default: return ID_VFR_HUD;
      endcase
   endfunction

   // Header: sync, length, sequence, system id, component id and message id.
   function automatic void start_frame(input logic [7:0] len, input logic [7:0] sys,
                                       input logic [7:0] id);
      frame_buf.delete();
      frame_buf.push_back(SYNC_BYTE);
      frame_buf.push_back(len);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(sys);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(id);
   endfunction

   // Appends the CRC, low byte first. A nonzero flip corrupts it on purpose.
   function automatic void seal_frame(input logic [15:0] flip);
      logic [15:0] crc;
      logic [7:0]  len;
      logic [7:0]  extra;
      crc = CRC_INIT;
      for (int i = 1; i < frame_buf.size(); i++) crc = x25_fold(crc, frame_buf[i]);
      void'(std_msg_params(frame_buf[5], len, extra));
      crc = x25_fold(crc, extra) ^ flip;
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
   endfunction

   // A frame of the given kind with random content. Broken headers stop after the message
   // id, since the parser is back to hunting from the next byte on.
   function automatic void build_random_frame(input frame_kind_type kind);
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] extra;
      logic [7:0] other;
      logic [7:0] dummy_len;
      logic [7:0] dummy_extra;
      id = pick_known_id($urandom_range(0, 5));
      void'(std_msg_params(id, len, extra));
      case (kind)
         FRAME_BAD_ID: begin
            do begin
               other = 8'($urandom);
            end while (std_msg_params(other, dummy_len, dummy_extra));
            start_frame(8'($urandom), 8'($urandom), other);
         end
         FRAME_BAD_LEN: begin
            do begin
               other = 8'($urandom);
            end while (other == len);
            start_frame(other, 8'($urandom), id);
         end
         default: begin
            start_frame(len, 8'($urandom), id);
            for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
            seal_frame(kind == FRAME_BAD_CRC ? 16'($urandom_range(1, 65535)) : 16'h0000);
         end
      endcase
   endfunction

   task automatic idle_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one byte and returns at the edge where it was taken.
   task automatic send_byte(input logic [7:0] b);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_rx_byte(b);
   endtask

   task automatic send_frame_buf(input bit allow_idle);
      foreach (frame_buf[i]) begin
         if (allow_idle && !calm_tail && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 7));
         send_byte(frame_buf[i]);
      end
   endtask

   // Stimulus. A short directed part first, then random frames, most of them good so that
   // the payload and CRC phases are reached often, with corrupted CRCs, unknown ids,
   // wrong lengths and line noise mixed in.
   initial begin
      int             frame_no;
      int             bytes_offered;
      int             roll;
      int             burst;
      logic [7:0]     noise;
      frame_kind_type kind;

      sb            = new();
      calm_tail     = 1'b0;
      long_hold_req = 1'b0;
      frames_good   = 0;
      frames_broken = 0;
      noise_bytes   = 0;
      reset         = 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes while hunting are dropped, including the all-zero and all-one bytes.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);

      // A good heartbeat whose payload carries the sync byte twice, which must be taken as
      // plain data, along with the byte extremes.
      start_frame(8'd9, 8'hFF, ID_HEARTBEAT);
      frame_buf = {frame_buf, 8'h00, 8'hFF, SYNC_BYTE, 8'h01, 8'h80, 8'h55, 8'hAA,
                   8'h7F, SYNC_BYTE};
      seal_frame(16'h0000);
      send_frame_buf(1'b0);
      frames_good++;

      // An unknown message id sends the parser back to hunting.
      start_frame(8'd9, 8'h00, 8'hFF);
      send_frame_buf(1'b0);
      frames_broken++;

      // A known id with the wrong length does the same.
      start_frame(8'd30, 8'h5A, ID_HEARTBEAT);
      send_frame_buf(1'b0);
      frames_broken++;

      bytes_offered = 0;
      frame_no      = 0;
      while (bytes_offered < TOTAL_BYTES) begin
         calm_tail = (bytes_offered >= CALM_TAIL_AT);

         // Midway, let every outstanding item drain before the next frame goes in.
         if (frame_no == 9) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (sb.expected_items.size() != 0);
         end

         roll = $urandom_range(0, 99);
         if (frame_no == 3) begin
            // This good frame is played out into a receiver that stops for a long time,
            // so the parser fills up and holds off the bytes that follow.
            kind          = FRAME_GOOD;
            long_hold_req = 1'b1;
         end else if (roll < 65) begin
            kind = FRAME_GOOD;
         end else if (roll < 75) begin
            kind = FRAME_BAD_CRC;
         end else if (roll < 82) begin
            kind = FRAME_BAD_ID;
         end else begin
            kind = FRAME_BAD_LEN;
         end

         if (frame_no != 3 && roll >= 90) begin
            // Line noise between frames, never containing the sync byte.
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               do begin
                  noise = 8'($urandom);
               end while (noise == SYNC_BYTE);
               send_byte(noise);
            end
            noise_bytes += burst;
         end else begin
            build_random_frame(kind);
            send_frame_buf($urandom_range(0, 3) != 0);
            bytes_offered += frame_buf.size();
            if (kind == FRAME_GOOD) frames_good++;
            else frames_broken++;
         end
         frame_no++;
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_items.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d good frames, %0d broken frames or headers and %0d noise bytes.",
               frames_good, frames_broken, noise_bytes);
      $display("%0d frames passed the CRC, %0d payload items checked, %0d mismatches.",
               sb.frames_passed, sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("mavlink_v1_frame_parser test passed");
      end else begin
         $display("mavlink_v1_frame_parser test failed");
      end
      $finish;
   end

   // Receiver. Each accepted item goes to the scoreboard; ready then follows random stall
   // bursts, calm stretches, the one long hold-off and a stall-free tail.
   initial begin
      int               hold_left;
      int               stall_left;
      bit               rsp_calm;
      payload_item_type got;

      hold_left  = 0;
      stall_left = 0;
      rsp_calm   = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.msg_id       = rsp_bus.msg_id;
            got.sys_id       = rsp_bus.sys_id;
            got.payload_byte = rsp_bus.payload_byte;
            got.byte_index   = rsp_bus.byte_index;
            got.last         = rsp_bus.last;
            got.gps_frame    = rsp_bus.gps_frame;
            sb.check_result(got);
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0 && !calm_tail) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm_tail && !rsp_calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = 0;
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no item moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      do @(posedge clock); while (reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Watchdog: %0d cycles without an accepted item, %0d items still expected.",
               quiet, sb.expected_items.size());
      $display("mavlink_v1_frame_parser test failed");
      $finish;
   end

endmodule

FILE: mavlink_v1_frame_parser.f
design/mvp_pkg.sv
design/mvp_req_if.sv
design/mvp_rsp_if.sv
design/mvp_ctrl.sv
design/mvp_dp.sv
design/mavlink_v1_frame_parser.sv
tb/tb_mavlink_v1_frame_parser.sv
